FILE: rtl/nwsm_pkg.sv
// Shared types, constants and register indexes for the score matrix hash unit.
package nwsm_pkg;

    // Default sizes of the stores
    localparam int DEF_MAX_COLS = 4096;
    localparam int DEF_SYMBOLS  = 32;

    // Fixed field widths
    localparam int SYM_FIELD_W = 5;
    localparam int SCORE_W     = 32;
    localparam int SUB_W       = 16;
    localparam int GAP_W       = 11;
    localparam int ROWS_W      = 16;
    localparam int COLS_W      = 13;
    localparam int TILE_W      = 11;
    localparam int PHASE_W     = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Hash seed
    localparam logic [SCORE_W-1:0] HASH_INIT = 32'd5381;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_PENALTY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 3'd4;

    // Configuration reset values
    localparam logic [GAP_W-1:0]  RST_GAP_PENALTY = 11'h7FF;
    localparam logic [ROWS_W-1:0] RST_MATRIX_ROWS = 16'd1;
    localparam logic [COLS_W-1:0] RST_MATRIX_COLS = 13'd1;
    localparam logic [TILE_W-1:0] RST_TILE_HEIGHT = 11'd33;
    localparam logic [TILE_W-1:0] RST_TILE_WIDTH  = 11'd33;

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CELL = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [SYM_FIELD_W-1:0] table_row;
        logic [SYM_FIELD_W-1:0] table_col;
        logic [SUB_W-1:0]       table_score;
        logic [SYM_FIELD_W-1:0] y_symbol;
        logic [SYM_FIELD_W-1:0] x_symbol;
        logic [SCORE_W-1:0]     header_score;
    } in_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] cell_score;
        logic [SCORE_W-1:0] running_hash;
        logic               from_header;
        logic               last;
    } out_item_t;

    // Position flags of the current cell, from the sequencer to the datapath
    typedef struct packed {
        logic hdr;
        logic last;
        logic row_nz;
        logic col_nz;
    } cell_flags_t;

endpackage

FILE: rtl/nw_score_matrix_hash_unit.sv
// Needleman-Wunsch linear-gap score matrix rebuilder with a running DJB2-xor hash.
//
// Channels: in (in_valid/in_ready/in_data) carries table loads and cells;
// out (out_valid/out_ready/out_data) carries one result per cell transfer;
// cfg (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the five registers, is
// always ready; the user must write it only while the block is idle (unenforced).
// Cells arrive in row-major order. A table load gives no result.
// A transferred cell waits in the compute stage; its result then goes to out.
// Throughput: one item per clock while out is taken. The previous-row memory is
// read in the transfer cycle and written back as the cell completes; a write to
// the entry the next cell reads is forwarded, so single-column matrices also run
// at full rate. Stall: the output register holds a result until it is taken; one
// more cell waits in the compute stage, and in_ready drops only when both are full.
// Reset clears counters, neighbor scores, the hash (to 5381) and the
// registers to their defaults. Both memories are left as they are and must
// be written (table loads, header row) before they are read.
module nw_score_matrix_hash_unit
    import nwsm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int SYMBOLS  = DEF_SYMBOLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_AW = $clog2(MAX_COLS);

    // Configuration registers
    logic [GAP_W-1:0]  gap_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    logic [TILE_W-1:0] th_reg;
    logic [TILE_W-1:0] tw_reg;

    // Pipeline and state
    logic               in_fire, cell_fire, load_fire;
    logic               s1_valid_reg, s1_fire;
    cell_flags_t        s1_flags_reg;
    logic [COL_AW-1:0]  s1_col_reg;
    logic [SCORE_W-1:0] s1_hdr_score_reg;
    logic [SCORE_W-1:0] diag_reg, left_reg, hash_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    cell_flags_t        cur_flags;
    logic [COL_AW-1:0]  cur_col;
    logic [SUB_W-1:0]   sub_q;
    logic [SCORE_W-1:0] up_q;

    logic [SCORE_W-1:0] gap_s, sub_s, p1, p2, p3, m12, score, hash_next;

    // Handshakes
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;
    assign cell_fire = in_fire && (in_data.mode == MODE_CELL);
    assign load_fire = in_fire && (in_data.mode == MODE_LOAD);
    assign cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg  <= RST_GAP_PENALTY;
            rows_reg <= RST_MATRIX_ROWS;
            cols_reg <= RST_MATRIX_COLS;
            th_reg   <= RST_TILE_HEIGHT;
            tw_reg   <= RST_TILE_WIDTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAP_PENALTY: gap_reg  <= cfg_data[GAP_W-1:0];
                CFG_MATRIX_ROWS: rows_reg <= cfg_data[ROWS_W-1:0];
                CFG_MATRIX_COLS: cols_reg <= cfg_data[COLS_W-1:0];
                CFG_TILE_HEIGHT: th_reg   <= cfg_data[TILE_W-1:0];
                CFG_TILE_WIDTH:  tw_reg   <= cfg_data[TILE_W-1:0];
                default: ;
            endcase
        end
    end

    nwsm_cell_seq #(
        .MAX_COLS(MAX_COLS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (cell_fire),
        .matrix_rows(rows_reg),
        .matrix_cols(cols_reg),
        .tile_height(th_reg),
        .tile_width (tw_reg),
        .flags      (cur_flags),
        .col        (cur_col)
    );

    nwsm_score_mem #(
        .MAX_COLS(MAX_COLS),
        .SYMBOLS (SYMBOLS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .tab_we   (load_fire),
        .tab_row  (in_data.table_row),
        .tab_col  (in_data.table_col),
        .tab_wdata(in_data.table_score),
        .rd_en    (cell_fire),
        .y_symbol (in_data.y_symbol),
        .x_symbol (in_data.x_symbol),
        .row_raddr(cur_col),
        .row_we   (s1_fire),
        .row_waddr(s1_col_reg),
        .row_wdata(score),
        .sub_q    (sub_q),
        .up_q     (up_q)
    );

    // Hold the cell in the compute stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= cell_fire;
    end

    always_ff @(posedge clk)
    begin
        if (cell_fire)
        begin
            s1_flags_reg     <= cur_flags;
            s1_col_reg       <= cur_col;
            s1_hdr_score_reg <= in_data.header_score;
        end
    end

    // Score the cell: header value, edge move, best of three moves or zero at the origin
    always_comb
    begin
        gap_s = {{(SCORE_W-GAP_W){gap_reg[GAP_W-1]}}, gap_reg};
        sub_s = {{(SCORE_W-SUB_W){sub_q[SUB_W-1]}}, sub_q};
        p1    = diag_reg + sub_s;
        p2    = up_q + gap_s;
        p3    = left_reg + gap_s;
        m12   = ($signed(p1) >= $signed(p2)) ? p1 : p2;
        if (s1_flags_reg.hdr)
            score = s1_hdr_score_reg;
        else if (s1_flags_reg.row_nz && s1_flags_reg.col_nz)
            score = ($signed(m12) >= $signed(p3)) ? m12 : p3;
        else if (s1_flags_reg.row_nz)
            score = p2;
        else if (s1_flags_reg.col_nz)
            score = p3;
        else
            score = '0;
        hash_next = ((hash_reg << 5) + hash_reg) ^ score;
    end

    // Update neighbor scores and the hash as each cell completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= '0;
            left_reg <= '0;
            hash_reg <= HASH_INIT;
        end
        else if (s1_fire)
        begin
            diag_reg <= up_q;
            left_reg <= score;
            hash_reg <= s1_flags_reg.last ? HASH_INIT : hash_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg.cell_score   <= score;
            out_data_reg.running_hash <= hash_next;
            out_data_reg.from_header  <= s1_flags_reg.hdr;
            out_data_reg.last         <= s1_flags_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Backpressure only when both the compute stage and the output are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

    // The hash restarts after the final cell of the matrix
    a_hash_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_flags_reg.last |=> hash_reg == HASH_INIT)
        else $error("hash did not restart after last cell");

    // A new result appears only from a completed cell
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire))
        else $error("result without a completed cell");

endmodule

FILE: rtl/nwsm_cell_seq.sv
// Row/column and tile phase counters that classify each matrix cell.
module nwsm_cell_seq
    import nwsm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int COL_AW  = $clog2(MAX_COLS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [ROWS_W-1:0] matrix_rows,
    input  logic [COLS_W-1:0] matrix_cols,
    input  logic [TILE_W-1:0] tile_height,
    input  logic [TILE_W-1:0] tile_width,
    output cell_flags_t       flags,
    output logic [COL_AW-1:0] col
);

    localparam logic [16:0] COLS_LIMIT = 17'(MAX_COLS);
    localparam logic [16:0] COLS_MAX_M1 = 17'(MAX_COLS - 1);

    logic [ROWS_W-1:0]  row_reg, row_next;
    logic [COL_AW-1:0]  col_reg, col_next;
    logic [PHASE_W-1:0] row_ph_reg, row_ph_next;
    logic [PHASE_W-1:0] col_ph_reg, col_ph_next;

    logic [ROWS_W-1:0]  rows_m1;
    logic [16:0]        cols_m1;
    logic [TILE_W-1:0]  th_c, tw_c;
    logic [PHASE_W-1:0] rper, cper;
    logic [PHASE_W-1:0] rp, cp;
    logic [PHASE_W:0]   rp_inc, cp_inc;
    logic               last_row, last_col;

    // Clamp the matrix and tile sizes
    always_comb
    begin
        rows_m1 = (matrix_rows == '0) ? '0 : matrix_rows - 1'b1;
        if (matrix_cols == '0)
            cols_m1 = '0;
        else if (17'(matrix_cols) > COLS_LIMIT)
            cols_m1 = COLS_MAX_M1;
        else
            cols_m1 = 17'(matrix_cols) - 17'd1;
        th_c = (tile_height < 11'd2) ? 11'd2 : ((tile_height > 11'd1024) ? 11'd1024 : tile_height);
        tw_c = (tile_width < 11'd2) ? 11'd2 : ((tile_width > 11'd1024) ? 11'd1024 : tile_width);
        rper = PHASE_W'(th_c - 11'd1);
        cper = PHASE_W'(tw_c - 11'd1);
    end

    // Classify the current cell
    always_comb
    begin
        rp       = (row_ph_reg >= rper) ? '0 : row_ph_reg;
        cp       = (col_ph_reg >= cper) ? '0 : col_ph_reg;
        last_row = row_reg >= rows_m1;
        last_col = 17'(col_reg) >= cols_m1;
        rp_inc   = {1'b0, rp} + 1'b1;
        cp_inc   = {1'b0, cp} + 1'b1;

        flags.hdr    = ((rp == '0) && !last_row) || ((cp == '0) && !last_col);
        flags.last   = last_row && last_col;
        flags.row_nz = row_reg != '0;
        flags.col_nz = col_reg != '0;
        col          = col_reg;
    end

    // Advance the position after each cell
    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        row_ph_next = rp;
        col_ph_next = cp;
        if (last_row && last_col)
        begin
            row_next    = '0;
            col_next    = '0;
            row_ph_next = '0;
            col_ph_next = '0;
        end
        else if (last_col)
        begin
            col_next    = '0;
            col_ph_next = '0;
            row_next    = row_reg + 1'b1;
            row_ph_next = (rp_inc >= {1'b0, rper}) ? '0 : rp_inc[PHASE_W-1:0];
        end
        else
        begin
            col_next    = col_reg + 1'b1;
            col_ph_next = (cp_inc >= {1'b0, cper}) ? '0 : cp_inc[PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            row_ph_reg <= '0;
            col_ph_reg <= '0;
        end
        else if (step)
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            row_ph_reg <= row_ph_next;
            col_ph_reg <= col_ph_next;
        end
    end

endmodule

FILE: rtl/nwsm_score_mem.sv
// Substitution table and previous-row score memories with write forwarding.
module nwsm_score_mem
    import nwsm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int SYMBOLS  = DEF_SYMBOLS,
    localparam int COL_AW  = $clog2(MAX_COLS),
    localparam int SYM_W   = $clog2(SYMBOLS),
    localparam int TAB_AW  = $clog2(SYMBOLS * SYMBOLS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tab_we,
    input  logic [SYM_FIELD_W-1:0] tab_row,
    input  logic [SYM_FIELD_W-1:0] tab_col,
    input  logic [SUB_W-1:0]       tab_wdata,
    input  logic                   rd_en,
    input  logic [SYM_FIELD_W-1:0] y_symbol,
    input  logic [SYM_FIELD_W-1:0] x_symbol,
    input  logic [COL_AW-1:0]      row_raddr,
    input  logic                   row_we,
    input  logic [COL_AW-1:0]      row_waddr,
    input  logic [SCORE_W-1:0]     row_wdata,
    output logic [SUB_W-1:0]       sub_q,
    output logic [SCORE_W-1:0]     up_q
);

    localparam int SYM_CODES = 1 << SYM_FIELD_W;

    logic [SUB_W-1:0]   subst_mem [SYMBOLS*SYMBOLS];
    logic [SCORE_W-1:0] row_mem [MAX_COLS];

    logic [SYM_W-1:0]   sym_mod [SYM_CODES];
    logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
    logic [SUB_W-1:0]   sub_q_reg;
    logic [SCORE_W-1:0] up_ram_reg;
    logic [SCORE_W-1:0] fwd_data_reg;
    logic               fwd_reg, fwd_next;

    // Reduce symbol codes modulo the alphabet size
    for (genvar i = 0; i < SYM_CODES; i++)
    begin : g_sym_mod
        assign sym_mod[i] = SYM_W'(i % SYMBOLS);
    end

    assign tab_waddr = TAB_AW'(TAB_AW'(sym_mod[tab_row]) * TAB_AW'(SYMBOLS))
                     + TAB_AW'(sym_mod[tab_col]);
    assign tab_raddr = TAB_AW'(TAB_AW'(sym_mod[y_symbol]) * TAB_AW'(SYMBOLS))
                     + TAB_AW'(sym_mod[x_symbol]);

    // Substitution table: write on load, read on cell transfer
    always_ff @(posedge clk)
    begin
        if (tab_we)
            subst_mem[tab_waddr] <= tab_wdata;
        if (rd_en)
            sub_q_reg <= subst_mem[tab_raddr];
    end

    // Previous-row scores: read the up neighbor, write back the new score
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        if (rd_en)
            up_ram_reg <= row_mem[row_raddr];
    end

    // Forward a write that lands on the entry being read in the same cycle
    assign fwd_next = rd_en ? (row_we && (row_waddr == row_raddr)) : fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else
            fwd_reg <= fwd_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            fwd_data_reg <= row_wdata;
    end

    assign sub_q = sub_q_reg;
    assign up_q  = fwd_reg ? fwd_data_reg : up_ram_reg;

endmodule

FILE: test/nw_score_matrix_hash_unit_checker.sv
// Checker for the score matrix hash unit: cell score predictor and result comparison.
`timescale 1ns / 100ps

module nw_score_matrix_hash_unit_checker
    import nwsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    outstanding
);

    localparam int MAX_COLS = DEF_MAX_COLS;

    // Shadow copy of the configuration registers
    logic [GAP_W-1:0]  gap_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    logic [TILE_W-1:0] tile_h_reg;
    logic [TILE_W-1:0] tile_w_reg;

    // Shadow copy of the matrix state
    logic [SUB_W-1:0]   sub_tbl [0:DEF_SYMBOLS*DEF_SYMBOLS-1];
    logic [SCORE_W-1:0] prev_row [0:MAX_COLS-1];
    logic [SCORE_W-1:0] diag_val;
    logic [SCORE_W-1:0] left_val;
    logic [ROWS_W-1:0]  row_idx;
    logic [11:0]        col_idx;
    int unsigned        row_ph;
    int unsigned        col_ph;
    logic [SCORE_W-1:0] hash_val;

    out_item_t expected_cells [$];
    int        results_seen;

    // Work out the next cell in row-major order and advance the position
    function automatic void score_next_cell(input in_item_t item, output out_item_t res);
        int unsigned        n_rows;
        int unsigned        n_cols;
        int unsigned        row_per;
        int unsigned        col_per;
        logic [SCORE_W-1:0] gap;
        logic [SCORE_W-1:0] up;
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] via_diag;
        logic [SCORE_W-1:0] via_up;
        logic [SCORE_W-1:0] via_left;
        logic [SUB_W-1:0]   sub;
        logic               at_last_row;
        logic               at_last_col;
        logic               is_hdr;

        // clamp sizes and tile periods to their legal ranges
        n_rows  = (rows_reg == 0) ? 1 : rows_reg;
        n_cols  = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        row_per = (tile_h_reg < 2) ? 1 : ((tile_h_reg > 1024) ? 1023 : tile_h_reg - 1);
        col_per = (tile_w_reg < 2) ? 1 : ((tile_w_reg > 1024) ? 1023 : tile_w_reg - 1);
        gap     = {{(SCORE_W-GAP_W){gap_reg[GAP_W-1]}}, gap_reg};

        if (row_ph >= row_per)
            row_ph = 0;
        if (col_ph >= col_per)
            col_ph = 0;

        at_last_row = row_idx >= n_rows - 1;
        at_last_col = col_idx >= n_cols - 1;
        up          = prev_row[col_idx];
        is_hdr      = (row_ph == 0 && !at_last_row) || (col_ph == 0 && !at_last_col);

        // pick the score source
        score = '0;
        if (is_hdr)
            score = item.header_score;
        else if (row_idx != 0 && col_idx != 0)
        begin
            sub      = sub_tbl[{item.y_symbol, item.x_symbol}];
            via_diag = diag_val + {{(SCORE_W-SUB_W){sub[SUB_W-1]}}, sub};
            via_up   = up + gap;
            via_left = left_val + gap;
            score    = via_diag;
            if ($signed(via_up) > $signed(score))
                score = via_up;
            if ($signed(via_left) > $signed(score))
                score = via_left;
        end
        else if (row_idx != 0)
            score = up + gap;
        else if (col_idx != 0)
            score = left_val + gap;

        diag_val          = up;
        left_val          = score;
        prev_row[col_idx] = score;
        hash_val          = (hash_val * 33) ^ score;

        res.cell_score   = score;
        res.running_hash = hash_val;
        res.from_header  = is_hdr;
        res.last         = at_last_row && at_last_col;

        // advance the position; restart after the final cell
        if (at_last_row && at_last_col)
        begin
            row_idx  = '0;
            col_idx  = '0;
            row_ph   = 0;
            col_ph   = 0;
            hash_val = HASH_INIT;
        end
        else if (at_last_col)
        begin
            col_idx = '0;
            col_ph  = 0;
            row_idx = row_idx + 1'b1;
            row_ph  = (row_ph + 1 >= row_per) ? 0 : row_ph + 1;
        end
        else
        begin
            col_idx = col_idx + 1'b1;
            col_ph  = (col_ph + 1 >= col_per) ? 0 : col_ph + 1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("cell %0d %s: expected %h, got %h", results_seen, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t want;
        if (!rst_n)
        begin
            gap_reg    = RST_GAP_PENALTY;
            rows_reg   = RST_MATRIX_ROWS;
            cols_reg   = RST_MATRIX_COLS;
            tile_h_reg = RST_TILE_HEIGHT;
            tile_w_reg = RST_TILE_WIDTH;
            diag_val   = '0;
            left_val   = '0;
            row_idx    = '0;
            col_idx    = '0;
            row_ph     = 0;
            col_ph     = 0;
            hash_val   = HASH_INIT;
            expected_cells.delete();
            outstanding = 0;
        end
        else
        begin
            // update the shadow register on a configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAP_PENALTY: gap_reg    = cfg_data[GAP_W-1:0];
                    CFG_MATRIX_ROWS: rows_reg   = cfg_data[ROWS_W-1:0];
                    CFG_MATRIX_COLS: cols_reg   = cfg_data[COLS_W-1:0];
                    CFG_TILE_HEIGHT: tile_h_reg = cfg_data[TILE_W-1:0];
                    CFG_TILE_WIDTH:  tile_w_reg = cfg_data[TILE_W-1:0];
                    default: ;
                endcase
            end

            // load the table or predict a cell on an input transfer
            if (in_valid && in_ready)
            begin
                if (in_data.mode == MODE_LOAD)
                    sub_tbl[{in_data.table_row, in_data.table_col}] = in_data.table_score;
                else
                begin
                    score_next_cell(in_data, want);
                    expected_cells = {expected_cells, want};
                end
            end

            // compare an output transfer with the oldest predicted cell
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_cells.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("cell %0d: result with no cell pending, got %h",
                                 results_seen, out_data);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    check_field("cell_score", want.cell_score, out_data.cell_score);
                    check_field("running_hash", want.running_hash, out_data.running_hash);
                    check_field("from_header", want.from_header, out_data.from_header);
                    check_field("last", want.last, out_data.last);
                end
            end
            outstanding = expected_cells.size();
        end
    end

endmodule

FILE: test/nw_score_matrix_hash_unit_test.sv
// Top of the score matrix hash unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module nw_score_matrix_hash_unit_test;
    import nwsm_pkg::*;

    localparam int IDLE_MAX     = 6;
    localparam int HOLD_CYCLES  = 40;
    localparam int TAIL_CYCLES  = 6;
    localparam int RANDOM_ITEMS = 330;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatch_count;
    int outstanding;
    bit no_gaps;
    bit hold_req;
    int random_items;

    nw_score_matrix_hash_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nw_score_matrix_hash_unit_checker cell_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #5_000_000;
        $display("nw_score_matrix_hash_unit_test NOT OK");
        $finish;
    end

    function automatic int draw_idle();
        if (no_gaps)
            return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic in_item_t random_item(input logic mode);
        logic [95:0] bits;
        in_item_t    item;
        bits      = {$urandom, $urandom, $urandom};
        item      = bits[$bits(in_item_t)-1:0];
        item.mode = mode;
        return item;
    endfunction

    function automatic logic [TILE_W-1:0] draw_tile();
        case ($urandom_range(0, 11))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;
            3:       return 11'd1024;
            4:       return 11'd33;
            default: return TILE_W'($urandom_range(2, 6));
        endcase
    endfunction

    // Accept results, stalling before each one for a random gap or a requested hold
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = draw_idle();
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input in_item_t item);
        int gap;
        gap = draw_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic park_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait for every predicted cell, then let the pipeline settle
    task automatic wait_drained();
        while (outstanding != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Write one register; bits above its width carry noise
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (width < CFG_DATA_W) ? ((junk << width) | value) : value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_sizes(input logic [GAP_W-1:0] gap, input logic [ROWS_W-1:0] rows,
                                 input logic [COLS_W-1:0] cols,
                                 input logic [TILE_W-1:0] tile_h,
                                 input logic [TILE_W-1:0] tile_w);
        write_reg(CFG_GAP_PENALTY, CFG_DATA_W'(gap), GAP_W);
        write_reg(CFG_MATRIX_ROWS, rows, ROWS_W);
        write_reg(CFG_MATRIX_COLS, CFG_DATA_W'(cols), COLS_W);
        write_reg(CFG_TILE_HEIGHT, CFG_DATA_W'(tile_h), TILE_W);
        write_reg(CFG_TILE_WIDTH, CFG_DATA_W'(tile_w), TILE_W);
    endtask

    // Start a huge matrix, then shrink it so that the next cell closes it
    task automatic run_open_matrix(input logic [ROWS_W-1:0] rows, input logic [COLS_W-1:0] cols,
                                   input logic [TILE_W-1:0] tile_h,
                                   input logic [TILE_W-1:0] tile_w, input int cells,
                                   input logic [ROWS_W-1:0] close_rows,
                                   input logic [COLS_W-1:0] close_cols);
        program_sizes(GAP_W'($urandom), rows, cols, tile_h, tile_w);
        repeat (cells) send_item(random_item(MODE_CELL));
        park_input();
        wait_drained();
        write_reg(CFG_MATRIX_ROWS, close_rows, ROWS_W);
        write_reg(CFG_MATRIX_COLS, CFG_DATA_W'(close_cols), COLS_W);
        repeat (2) send_item(random_item(MODE_CELL));
        park_input();
        wait_drained();
    endtask

    initial
    begin
        logic [SCORE_W-1:0] extreme_scores [4];
        in_item_t           item;
        logic [GAP_W-1:0]   gap_v;
        logic [ROWS_W-1:0]  rows_v;
        logic [COLS_W-1:0]  cols_v;
        int                 cells;
        int                 phase;

        extreme_scores = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

        // Hold reset with every input at a known value
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        random_items = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Fill the whole substitution table, extremes in the corners
        for (int r = 0; r < DEF_SYMBOLS; r++)
        begin
            for (int c = 0; c < DEF_SYMBOLS; c++)
            begin
                item           = random_item(MODE_LOAD);
                item.table_row = SYM_FIELD_W'(r);
                item.table_col = SYM_FIELD_W'(c);
                if ((r == 0 || r == DEF_SYMBOLS - 1) && (c == 0 || c == DEF_SYMBOLS - 1))
                begin
                    case ({r != 0, c != 0})
                        2'b00:   item.table_score = 16'h8000;
                        2'b11:   item.table_score = 16'h7FFF;
                        2'b01:   item.table_score = 16'h0000;
                        default: item.table_score = 16'hFFFF;
                    endcase
                end
                send_item(item);
            end
        end

        // Single-cell matrices under the reset configuration
        repeat (2) send_item(random_item(MODE_CELL));
        park_input();
        wait_drained();

        // Every row and column but the last is a header; hold off the receiver meanwhile
        program_sizes(11'h400, 16'd3, 13'd3, 11'd2, 11'd2);
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (int k = 0; k < 9; k++)
        begin
            item              = random_item(MODE_CELL);
            item.header_score = extreme_scores[k % 4];
            send_item(item);
        end
        park_input();
        wait_drained();
        no_gaps = 1'b0;

        // Only row 0 and column 0 are headers; interior cells hit table corners
        program_sizes(11'h3FF, 16'd3, 13'd5, 11'd1024, 11'd1024);
        for (int k = 0; k < 15; k++)
        begin
            item              = random_item(MODE_CELL);
            item.header_score = extreme_scores[k % 4];
            item.y_symbol     = {SYM_FIELD_W{k[0]}};
            item.x_symbol     = {SYM_FIELD_W{k[0] ^ k[1]}};
            send_item(item);
        end
        park_input();
        wait_drained();

        // Unused register indexes change nothing
        for (int k = CFG_TILE_WIDTH + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom), CFG_DATA_W);

        // Out-of-range and maximal sizes, closed by shrinking mid-matrix
        run_open_matrix(16'd0, 13'd8191, 11'd1, 11'd2047, 20, 16'd1, 13'd0);
        run_open_matrix(16'd65535, 13'd4096, 11'd1024, 11'd2, 20, 16'd0, 13'd1);
        run_open_matrix(16'd65535, 13'd1, 11'd3, 11'd0, 25, 16'd1, 13'd1);

        // Random phases of whole matrices with table reloads mixed in
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       gap_v = 11'h400;
                1:       gap_v = 11'h3FF;
                default: gap_v = GAP_W'($urandom);
            endcase
            rows_v = ($urandom_range(0, 15) == 0) ? 16'd0 : ROWS_W'($urandom_range(1, 8));
            case ($urandom_range(0, 15))
                0:       cols_v = 13'd0;
                1:       cols_v = COLS_W'($urandom_range(11, 40));
                default: cols_v = COLS_W'($urandom_range(1, 10));
            endcase
            program_sizes(gap_v, rows_v, cols_v, draw_tile(), draw_tile());
            cells = $urandom_range(1, 3) * ((rows_v == 0) ? 1 : rows_v)
                    * ((cols_v == 0) ? 1 : cols_v);

            @(posedge clk);
            hold_req = (phase == 0) || ($urandom_range(0, 5) == 0);
            no_gaps  = hold_req || ($urandom_range(0, 3) == 0);

            repeat (cells)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(random_item(MODE_LOAD));
                    random_items++;
                end
                send_item(random_item(MODE_CELL));
                random_items++;
            end
            park_input();
            wait_drained();
            phase++;
        end

        if (mismatch_count == 0 && outstanding == 0)
            $display("nw_score_matrix_hash_unit_test OK");
        else
            $display("nw_score_matrix_hash_unit_test NOT OK");
        $finish;
    end

endmodule
